>>> sv/tsis_pkg.sv
// ----------------------------------------------------------------------------
// tsis_pkg
// Shared types and constants for the time series interpolating store.
// ----------------------------------------------------------------------------
`default_nettype none

package tsis_pkg;

    localparam int DEPTH   = 1024;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = AW + 1;

    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_ORDER = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_RANGE = 3'd4;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic          latch_in;   // capture the input item
        logic          do_append;  // write the pair and update summaries
        logic [AW-1:0] rd_addr;
        logic          cap_a;      // capture read data as the lower pair
        logic          cap_b;      // capture read data as the upper pair
        logic          mul_start;  // form the product magnitude
        logic          div_start;  // start the divider
        logic [1:0]    res_sel;    // which value to report
        logic [2:0]    status;
        logic          emit;       // strobe the result
    } t_cmd;

    localparam logic [1:0] RES_ZERO   = 2'd0;
    localparam logic [1:0] RES_A      = 2'd1;  // value of lower pair
    localparam logic [1:0] RES_INTERP = 2'd2;
    localparam logic [1:0] RES_PAIR   = 2'd3;  // value and time of lower pair

    typedef struct packed {
        logic [1:0]    kind;
        logic [CW-1:0] count;
        logic [AW-1:0] index;
        logic          q_ge_last;
        logic          q_le_first;
        logic          q_lt_last_t;  // query time below last stored time
        logic          rd_le_q;      // last read time at or below query
        logic          div_done;
    } t_sts;

endpackage

`default_nettype wire

>>> sv/time_series_interpolating_store.sv
// ----------------------------------------------------------------------------
// time_series_interpolating_store
// Table of (time, value) pairs with append, interpolating lookup and read.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue one command; exactly one result
// appears on the o_ ports for a single cycle, marked by o_valid, and the
// receiver cannot stall it, so it must take every transfer as it comes.
// An interpolating lookup walks a binary search over the table, one table
// read per search step, and then waits for the bit-serial divider. The table
// memories reset to unknown contents, but only data read from entries below
// the fill count is used.
// ----------------------------------------------------------------------------
`default_nettype none

module time_series_interpolating_store import tsis_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_in_time,
    input  wire logic [31:0] i_in_value,
    input  wire logic [9:0]  i_entry_index,
    output logic             o_valid,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_out_value,
    output logic      [31:0] o_out_time,
    output logic      [10:0] o_entry_count,
    output logic      [31:0] o_min_value,
    output logic      [31:0] o_max_value,
    output logic      [31:0] o_first_time,
    output logic      [31:0] o_last_time
);

    t_cmd w_cmd;
    t_sts w_sts;

    // The controller sequences each command; the datapath owns all storage.
    tsis_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_sts(w_sts), .o_cmd(w_cmd)
    );

    tsis_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_kind(i_kind), .i_in_time(i_in_time), .i_in_value(i_in_value),
        .i_entry_index(i_entry_index), .o_status(o_status),
        .o_out_value(o_out_value), .o_out_time(o_out_time),
        .o_entry_count(o_entry_count), .o_min_value(o_min_value),
        .o_max_value(o_max_value), .o_first_time(o_first_time),
        .o_last_time(o_last_time), .o_valid(o_valid)
    );

endmodule

`default_nettype wire

>>> sv/tsis_ram.sv
// ----------------------------------------------------------------------------
// tsis_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> sv/tsis_div.sv
// ----------------------------------------------------------------------------
// tsis_div
// Unsigned 64 by 33 bit restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tsis_div import tsis_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [32:0] i_den,
    output logic      [63:0] o_quo,
    output logic             o_done
);

    logic [63:0] r_quo;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] n_trial;
    logic [34:0] n_diff;

    always_comb begin
        n_trial = {r_rem[32:0], r_quo[63]};
        n_diff  = {1'b0, n_trial} - {2'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!n_diff[34]) begin
                r_rem <= n_diff[33:0];
                r_quo <= {r_quo[62:0], 1'b1};
            end else begin
                r_rem <= n_trial;
                r_quo <= {r_quo[62:0], 1'b0};
            end
        end
    end

    assign o_quo = r_quo;

endmodule

`default_nettype wire

>>> sv/tsis_datapath.sv
// ----------------------------------------------------------------------------
// tsis_datapath
// Stores, summary registers, compares and interpolation arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module tsis_datapath import tsis_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_in_time,
    input  wire logic [31:0] i_in_value,
    input  wire logic [9:0]  i_entry_index,
    output logic      [2:0]  o_status,
    output logic      [31:0] o_out_value,
    output logic      [31:0] o_out_time,
    output logic      [10:0] o_entry_count,
    output logic      [31:0] o_min_value,
    output logic      [31:0] o_max_value,
    output logic      [31:0] o_first_time,
    output logic      [31:0] o_last_time,
    output logic             o_valid
);

    logic [1:0]    r_kind;
    logic [31:0]   r_q;
    logic [31:0]   r_v;
    logic [AW-1:0] r_idx;
    logic [CW-1:0] r_count;
    logic [31:0]   r_min, r_max, r_first, r_last;
    logic [31:0]   r_ta, r_va, r_tb, r_vb;
    logic [63:0]   r_mag;
    logic          r_neg;
    logic [31:0]   w_rt, w_rv;
    logic [AW-1:0] w_addr;
    logic          w_we;
    logic [32:0]   w_dq, w_dv, w_dt, w_dvmag;
    logic [63:0]   w_quo;
    logic          w_done;
    logic [31:0]   w_interp;

    assign w_we   = i_cmd.do_append;
    assign w_addr = w_we ? r_count[AW-1:0] : i_cmd.rd_addr;

    tsis_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_q), .o_rdata(w_rt)
    );
    tsis_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(r_v), .o_rdata(w_rv)
    );

    assign w_dq    = {r_q[31], r_q} - {r_ta[31], r_ta};
    assign w_dv    = {r_vb[31], r_vb} - {r_va[31], r_va};
    assign w_dt    = {r_tb[31], r_tb} - {r_ta[31], r_ta};
    assign w_dvmag = w_dv[32] ? (33'd0 - w_dv) : w_dv;

    tsis_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num(r_mag), .i_den(w_dt), .o_quo(w_quo), .o_done(w_done)
    );

    assign w_interp = r_neg ? (r_va - w_quo[31:0]) : (r_va + w_quo[31:0]);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_kind <= i_kind;
            r_q    <= i_in_time;
            r_v    <= i_in_value;
            r_idx  <= i_entry_index[AW-1:0];
        end
        if (i_cmd.cap_a) begin
            r_ta <= w_rt;
            r_va <= w_rv;
        end
        if (i_cmd.cap_b) begin
            r_tb <= w_rt;
            r_vb <= w_rv;
        end
        if (i_cmd.mul_start) begin
            r_mag <= 64'(w_dq[31:0]) * 64'(w_dvmag[31:0]);
            r_neg <= w_dv[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_first <= '0;
            r_last  <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            if (i_cmd.do_append) begin
                r_count <= r_count + 1'b1;
                r_last  <= r_q;
                if (r_count == '0) begin
                    r_first <= r_q;
                end
                if (r_count == '0 || $signed(r_v) > $signed(r_max)) begin
                    r_max <= r_v;
                end
                if (r_count == '0 || $signed(r_v) < $signed(r_min)) begin
                    r_min <= r_v;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status <= i_cmd.status;
            unique case (i_cmd.res_sel)
                RES_ZERO: begin
                    o_out_value <= '0;
                    o_out_time  <= '0;
                end
                RES_A: begin
                    o_out_value <= r_va;
                    o_out_time  <= '0;
                end
                RES_INTERP: begin
                    o_out_value <= w_interp;
                    o_out_time  <= '0;
                end
                RES_PAIR: begin
                    o_out_value <= r_va;
                    o_out_time  <= r_ta;
                end
                default: begin
                    o_out_value <= '0;
                    o_out_time  <= '0;
                end
            endcase
        end
    end

    assign o_entry_count = 11'(r_count);
    assign o_min_value   = r_min;
    assign o_max_value   = r_max;
    assign o_first_time  = r_first;
    assign o_last_time   = r_last;

    always_comb begin
        o_sts.kind        = r_kind;
        o_sts.count       = r_count;
        o_sts.index       = r_idx;
        o_sts.q_ge_last   = $signed(r_q) >= $signed(r_last);
        o_sts.q_le_first  = $signed(r_q) <= $signed(r_first);
        o_sts.q_lt_last_t = $signed(r_q) < $signed(r_last);
        o_sts.rd_le_q     = $signed(w_rt) <= $signed(r_q);
        o_sts.div_done    = w_done;
    end

endmodule

`default_nettype wire

>>> sv/tsis_ctrl.sv
// ----------------------------------------------------------------------------
// tsis_ctrl
// Controller: decodes each command and runs the search and interpolation.
// ----------------------------------------------------------------------------
`default_nettype none

module tsis_ctrl import tsis_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_SWAIT  = 4'd4;
    localparam logic [3:0] S_LOA    = 4'd5;
    localparam logic [3:0] S_LOB    = 4'd6;
    localparam logic [3:0] S_MUL    = 4'd7;
    localparam logic [3:0] S_DIVGO  = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_RDEND  = 4'd10;
    localparam logic [3:0] S_CLAMP  = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0] w_mid;
    logic [1:0]    r_sel, n_sel;  // clamp selection reuses res_sel

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign busy  = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_sel   = r_sel;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_sts.kind == KIND_APPEND) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                    if (i_sts.count != '0 && i_sts.q_lt_last_t) begin
                        o_cmd.status = ST_ORDER;
                    end else if (i_sts.count >= CW'(DEPTH)) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.do_append = 1'b1;
                    end
                end else if (i_sts.kind == KIND_LOOKUP) begin
                    if (i_sts.count == '0) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_EMPTY;
                        n_state      = S_IDLE;
                    end else if (i_sts.q_ge_last) begin
                        o_cmd.rd_addr = AW'(i_sts.count - 1'b1);
                        n_state       = S_CLAMP;
                    end else if (i_sts.q_le_first) begin
                        o_cmd.rd_addr = '0;
                        n_state       = S_CLAMP;
                    end else begin
                        n_lo    = '0;
                        n_hi    = i_sts.count - 1'b1;
                        n_state = S_SRCH;
                    end
                end else if (i_sts.kind == KIND_READ) begin
                    if (CW'(i_sts.index) >= i_sts.count) begin
                        o_cmd.emit   = 1'b1;
                        o_cmd.status = ST_RANGE;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.rd_addr = i_sts.index;
                        n_state       = S_RDWAIT;
                    end
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_RDWAIT: begin
                o_cmd.cap_a = 1'b1;
                n_state     = S_RDEND;
            end
            S_RDEND: begin
                o_cmd.emit    = 1'b1;
                o_cmd.res_sel = RES_PAIR;
                n_state       = S_IDLE;
            end
            S_CLAMP: begin
                // Read data of the clamp entry arrives here.
                o_cmd.cap_a = 1'b1;
                n_state     = S_RDEND;
                n_sel       = RES_A;
            end
            S_SRCH: begin
                if (r_hi - r_lo > CW'(1)) begin
                    o_cmd.rd_addr = w_mid[AW-1:0];
                    n_state       = S_SWAIT;
                end else begin
                    o_cmd.rd_addr = r_lo[AW-1:0];
                    n_state       = S_LOA;
                end
            end
            S_SWAIT: begin
                if (i_sts.rd_le_q) begin
                    n_lo = w_mid;
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_SRCH;
            end
            S_LOA: begin
                o_cmd.cap_a   = 1'b1;
                o_cmd.rd_addr = AW'(r_lo + 1'b1);
                n_state       = S_LOB;
            end
            S_LOB: begin
                o_cmd.cap_b = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state         = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.res_sel = RES_INTERP;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // Lookup clamps report the value only; index reads report the pair.
        if (r_state == S_RDEND && r_sel == RES_A) begin
            o_cmd.res_sel = RES_A;
            n_sel         = RES_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= RES_ZERO;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo <= n_lo;
        r_hi <= n_hi;
    end

endmodule

`default_nettype wire
